// File: src/xts_pkg.sv
package xts_pkg;

   localparam int unsigned TOKEN_LIMIT = 511;
   localparam int unsigned MAX_RESULTS = 6;

   typedef enum logic [3:0] {
      MODE_IDLE    = 4'd0,
      MODE_TEXT    = 4'd1,
      MODE_LOOK    = 4'd2,
      MODE_ELEM    = 4'd3,
      MODE_END     = 4'd4,
      MODE_ASPACE  = 4'd5,
      MODE_ANAME   = 4'd6,
      MODE_AEQ     = 4'd7,
      MODE_AQUOTE  = 4'd8,
      MODE_AVAL    = 4'd9,
      MODE_COMMENT = 4'd10,
      MODE_DECL    = 4'd11
   } mode_type;

   typedef enum logic [2:0] {
      KIND_TEXT    = 3'd0,
      KIND_ELEM    = 3'd1,
      KIND_END     = 3'd2,
      KIND_ANAME   = 3'd3,
      KIND_AVAL    = 3'd4,
      KIND_COMMENT = 3'd5,
      KIND_DECL    = 3'd6
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_QUOTE     = 2'd1,
      ERR_COMMENT   = 2'd2,
      ERR_DECL      = 2'd3
   } err_type;

   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_QMARK = 8'h3F;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_DQ    = 8'h22;
   localparam logic [7:0] CH_SQ    = 8'h27;
   localparam logic [7:0] CH_X     = 8'h78;
   localparam logic [7:0] CH_M     = 8'h6D;
   localparam logic [7:0] CH_L     = 8'h6C;

   function automatic logic is_name(input logic [7:0] c);
      is_name = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
                c == 8'h5F || c == 8'h2E || c == CH_DASH;
   endfunction

   // opener byte at position idx: comment "<!--", declaration "<?xml"
   function automatic logic [7:0] opener_byte(input logic is_com, input logic [2:0] idx);
      logic [7:0] r;
      r = 8'h00;
      case (idx)
         3'd2: r = is_com ? CH_DASH : CH_X;
         3'd3: r = is_com ? CH_DASH : CH_M;
         3'd4: r = CH_L;
         default: r = 8'h00;
      endcase
      opener_byte = r;
   endfunction

endpackage

// File: src/xml_token_scanner.sv
// Throughput: one scan step per cycle while an item is held; an item takes one step per
// result, consumed byte or re-dispatch.
// The scan engine stalls only while the result register is held by rsp_stall.
// Reset (synchronous, active high) returns the lexer to text level and empties
// both registers; lookahead bytes are not cleared.
module xml_token_scanner (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_node_kind,
   output logic [7:0] rsp_content_byte,
   output logic       rsp_content_valid,
   output logic       rsp_node_done,
   output logic [1:0] rsp_error_code
);

   xts_pkg::mode_type mode_ff, mode_in;
   logic [7:0] la_ff [4];
   logic [7:0] la_in [4];
   logic [2:0] la_cnt_ff, la_cnt_in;
   logic       inside_ff, inside_in;
   logic       dquote_ff, dquote_in;
   logic [8:0] tlen_ff, tlen_in;
   logic [2:0] rp_pos_ff, rp_pos_in;
   logic [2:0] rp_end_ff, rp_end_in;
   logic       c_done_ff, c_done_in;
   logic [2:0] emit_cnt_ff, emit_cnt_in;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [2:0] rsp_kind_ff;
   logic [7:0] rsp_byte_ff;
   logic       rsp_cvalid_ff;
   logic       rsp_done_ff;
   logic [1:0] rsp_err_ff;

   logic       out_free, step_en, replaying, finishing, accept, item_done;
   logic       consume, emit, emit_ok, is_com, below_limit;
   logic [7:0] cur;
   logic [2:0] n;
   xts_pkg::kind_type e_kind;
   logic [7:0] e_byte;
   logic       e_cvalid, e_done;
   xts_pkg::err_type e_err;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign step_en   = in_valid_ff && out_free;
   assign replaying = rp_pos_ff < rp_end_ff;
   assign finishing = !replaying && c_done_ff;
   assign cur       = replaying ? la_ff[rp_pos_ff[1:0]] : in_byte_ff;
   assign below_limit = tlen_ff < 9'(xts_pkg::TOKEN_LIMIT);
   assign is_com    = la_ff[1] == xts_pkg::CH_BANG;
   assign n         = (la_cnt_ff == 3'd0) ? 3'd1 : (la_cnt_ff > 3'd4) ? 3'd4 : la_cnt_ff;

   always_comb begin
      mode_in   = mode_ff;
      la_in     = la_ff;
      la_cnt_in = la_cnt_ff;
      inside_in = inside_ff;
      dquote_in = dquote_ff;
      tlen_in   = tlen_ff;
      rp_pos_in = rp_pos_ff;
      rp_end_in = rp_end_ff;
      c_done_in = c_done_ff;
      consume   = 1'b0;
      emit      = 1'b0;
      e_kind    = xts_pkg::KIND_TEXT;
      e_byte    = 8'h00;
      e_cvalid  = 1'b0;
      e_done    = 1'b0;
      e_err     = xts_pkg::ERR_NONE;
      item_done = 1'b0;

      if (finishing) begin
         if (mode_ff == xts_pkg::MODE_LOOK) begin
            rp_pos_in = 3'd1;
            rp_end_in = n;
            la_cnt_in = 3'd0;
            mode_in   = xts_pkg::MODE_ELEM;
            tlen_in   = 9'd0;
         end else begin
            e_done = 1'b1;
            case (mode_ff)
               xts_pkg::MODE_TEXT: begin
                  emit = 1'b1; e_kind = xts_pkg::KIND_TEXT;
               end
               xts_pkg::MODE_ELEM: begin
                  emit = 1'b1; e_kind = xts_pkg::KIND_ELEM;
               end
               xts_pkg::MODE_END: begin
                  emit = 1'b1; e_kind = xts_pkg::KIND_END;
               end
               xts_pkg::MODE_ASPACE, xts_pkg::MODE_ANAME, xts_pkg::MODE_AEQ,
               xts_pkg::MODE_AQUOTE, xts_pkg::MODE_AVAL: begin
                  emit = 1'b1; e_kind = xts_pkg::KIND_AVAL; e_err = xts_pkg::ERR_QUOTE;
               end
               xts_pkg::MODE_COMMENT: begin
                  emit = 1'b1; e_kind = xts_pkg::KIND_COMMENT; e_err = xts_pkg::ERR_COMMENT;
               end
               xts_pkg::MODE_DECL: begin
                  emit = 1'b1; e_kind = xts_pkg::KIND_DECL; e_err = xts_pkg::ERR_DECL;
               end
               default: emit = 1'b0;
            endcase
            item_done = 1'b1;
            mode_in   = xts_pkg::MODE_IDLE;
            la_cnt_in = 3'd0;
            inside_in = 1'b0;
            dquote_in = 1'b0;
            tlen_in   = 9'd0;
            rp_pos_in = 3'd0;
            rp_end_in = 3'd0;
         end
      end else begin
         case (mode_ff)
            xts_pkg::MODE_IDLE: begin
               if (cur == xts_pkg::CH_LT) begin
                  la_in[0] = cur; la_cnt_in = 3'd1; mode_in = xts_pkg::MODE_LOOK;
                  consume = 1'b1;
               end else if (cur == xts_pkg::CH_SPACE && inside_ff) begin
                  mode_in = xts_pkg::MODE_ASPACE; tlen_in = 9'd0; consume = 1'b1;
               end else if (cur == xts_pkg::CH_GT && inside_ff) begin
                  inside_in = 1'b0; consume = 1'b1;
               end else begin
                  mode_in = xts_pkg::MODE_TEXT; tlen_in = 9'd0;
               end
            end
            xts_pkg::MODE_TEXT: begin
               e_kind = xts_pkg::KIND_TEXT;
               if (cur == xts_pkg::CH_LT) begin
                  emit = 1'b1; e_done = 1'b1; mode_in = xts_pkg::MODE_IDLE;
               end else if (cur == xts_pkg::CH_LF) begin
                  consume = 1'b1;
               end else if (below_limit) begin
                  emit = 1'b1; e_byte = cur; e_cvalid = 1'b1;
                  tlen_in = tlen_ff + 9'd1; consume = 1'b1;
               end else begin
                  emit = 1'b1; e_done = 1'b1; mode_in = xts_pkg::MODE_IDLE;
               end
            end
            xts_pkg::MODE_LOOK: begin
               if (n == 3'd1 && cur == xts_pkg::CH_SLASH) begin
                  la_cnt_in = 3'd0; mode_in = xts_pkg::MODE_END; tlen_in = 9'd0;
                  consume = 1'b1;
               end else if (n == 3'd1 &&
                            (cur == xts_pkg::CH_BANG || cur == xts_pkg::CH_QMARK)) begin
                  la_in[1] = cur; la_cnt_in = 3'd2; consume = 1'b1;
               end else if (n != 3'd1 && n < (is_com ? 3'd4 : 3'd5) &&
                            cur == xts_pkg::opener_byte(is_com, n)) begin
                  consume = 1'b1;
                  if (n + 3'd1 == (is_com ? 3'd4 : 3'd5)) begin
                     la_cnt_in = 3'd0;
                     mode_in   = is_com ? xts_pkg::MODE_COMMENT : xts_pkg::MODE_DECL;
                  end else begin
                     la_in[n[1:0]] = cur;
                     la_cnt_in     = n + 3'd1;
                  end
               end else begin
                  // failed opener: '<' starts an element, buffered bytes go again
                  rp_pos_in = 3'd1;
                  rp_end_in = n;
                  la_cnt_in = 3'd0;
                  mode_in   = xts_pkg::MODE_ELEM;
                  tlen_in   = 9'd0;
               end
            end
            xts_pkg::MODE_ELEM: begin
               e_kind = xts_pkg::KIND_ELEM;
               if (xts_pkg::is_name(cur) && below_limit) begin
                  emit = 1'b1; e_byte = cur; e_cvalid = 1'b1;
                  tlen_in = tlen_ff + 9'd1; consume = 1'b1;
               end else if (xts_pkg::is_name(cur)) begin
                  emit = 1'b1; e_done = 1'b1; mode_in = xts_pkg::MODE_IDLE;
               end else begin
                  emit = 1'b1; e_done = 1'b1; mode_in = xts_pkg::MODE_IDLE;
                  if (cur == xts_pkg::CH_GT) begin
                     inside_in = 1'b0; consume = 1'b1;
                  end else begin
                     inside_in = 1'b1;
                  end
               end
            end
            xts_pkg::MODE_END: begin
               e_kind = xts_pkg::KIND_END;
               if (xts_pkg::is_name(cur)) begin
                  consume = 1'b1;
                  if (below_limit) begin
                     emit = 1'b1; e_byte = cur; e_cvalid = 1'b1; tlen_in = tlen_ff + 9'd1;
                  end
               end else begin
                  emit = 1'b1; e_done = 1'b1; inside_in = 1'b0;
                  mode_in = xts_pkg::MODE_IDLE;
                  consume = cur == xts_pkg::CH_GT;
               end
            end
            xts_pkg::MODE_ASPACE: begin
               if (cur == xts_pkg::CH_SPACE || cur == xts_pkg::CH_TAB) begin
                  consume = 1'b1;
               end else begin
                  mode_in = xts_pkg::is_name(cur) ? xts_pkg::MODE_ANAME : xts_pkg::MODE_AEQ;
               end
            end
            xts_pkg::MODE_ANAME: begin
               e_kind = xts_pkg::KIND_ANAME;
               if (xts_pkg::is_name(cur)) begin
                  consume = 1'b1;
                  if (below_limit) begin
                     emit = 1'b1; e_byte = cur; e_cvalid = 1'b1; tlen_in = tlen_ff + 9'd1;
                  end
               end else begin
                  mode_in = xts_pkg::MODE_AEQ;
               end
            end
            xts_pkg::MODE_AEQ: begin
               consume = 1'b1;
               if (cur == xts_pkg::CH_EQ) mode_in = xts_pkg::MODE_AQUOTE;
            end
            xts_pkg::MODE_AQUOTE: begin
               e_kind = xts_pkg::KIND_AVAL;
               if (cur == xts_pkg::CH_DQ || cur == xts_pkg::CH_SQ) begin
                  dquote_in = cur == xts_pkg::CH_DQ;
                  tlen_in   = 9'd0;
                  mode_in   = xts_pkg::MODE_AVAL;
                  consume   = 1'b1;
               end else begin
                  emit = 1'b1; e_done = 1'b1; e_err = xts_pkg::ERR_QUOTE;
                  mode_in = xts_pkg::MODE_IDLE;
               end
            end
            xts_pkg::MODE_AVAL: begin
               e_kind  = xts_pkg::KIND_AVAL;
               consume = 1'b1;
               if (cur == (dquote_ff ? xts_pkg::CH_DQ : xts_pkg::CH_SQ)) begin
                  emit = 1'b1; e_done = 1'b1; mode_in = xts_pkg::MODE_IDLE;
               end else if (below_limit) begin
                  emit = 1'b1; e_byte = cur; e_cvalid = 1'b1; tlen_in = tlen_ff + 9'd1;
               end
            end
            xts_pkg::MODE_COMMENT: begin
               e_kind  = xts_pkg::KIND_COMMENT;
               consume = 1'b1;
               if (cur == xts_pkg::CH_DASH) begin
                  if (la_cnt_ff < 3'd2) la_cnt_in = la_cnt_ff + 3'd1;
               end else if (cur == xts_pkg::CH_GT && la_cnt_ff >= 3'd2) begin
                  emit = 1'b1; e_done = 1'b1; la_cnt_in = 3'd0;
                  mode_in = xts_pkg::MODE_IDLE;
               end else begin
                  la_cnt_in = 3'd0;
               end
            end
            xts_pkg::MODE_DECL: begin
               e_kind  = xts_pkg::KIND_DECL;
               consume = 1'b1;
               if (cur == xts_pkg::CH_GT && la_cnt_ff != 3'd0) begin
                  emit = 1'b1; e_done = 1'b1; la_cnt_in = 3'd0;
                  mode_in = xts_pkg::MODE_IDLE;
               end else begin
                  la_cnt_in = (cur == xts_pkg::CH_QMARK) ? 3'd1 : 3'd0;
               end
            end
            default: mode_in = xts_pkg::MODE_IDLE;
         endcase

         if (consume) begin
            if (replaying) begin
               rp_pos_in = rp_pos_ff + 3'd1;
            end else begin
               c_done_in = 1'b1;
               item_done = !in_last_ff;
            end
         end
      end
   end

   assign emit_ok   = emit && (emit_cnt_ff < 3'(xts_pkg::MAX_RESULTS));
   assign accept    = req_valid && !req_stall;
   assign req_stall = in_valid_ff && !(step_en && item_done);

   always_comb begin
      in_valid_in = in_valid_ff;
      if (step_en && item_done) in_valid_in = 1'b0;
      if (accept) in_valid_in = 1'b1;
      rsp_valid_in = rsp_valid_ff;
      if (out_free) rsp_valid_in = step_en && emit_ok;
      emit_cnt_in = emit_cnt_ff;
      if (step_en && emit_ok) emit_cnt_in = emit_cnt_ff + 3'd1;
      if (accept) emit_cnt_in = 3'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= xts_pkg::MODE_IDLE;
         la_cnt_ff    <= 3'd0;
         inside_ff    <= 1'b0;
         dquote_ff    <= 1'b0;
         tlen_ff      <= 9'd0;
         rp_pos_ff    <= 3'd0;
         rp_end_ff    <= 3'd0;
         c_done_ff    <= 1'b0;
         emit_cnt_ff  <= 3'd0;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         emit_cnt_ff  <= emit_cnt_in;
         if (step_en) begin
            mode_ff   <= mode_in;
            la_cnt_ff <= la_cnt_in;
            inside_ff <= inside_in;
            dquote_ff <= dquote_in;
            tlen_ff   <= tlen_in;
            rp_pos_ff <= rp_pos_in;
            rp_end_ff <= rp_end_in;
         end
         if (accept) c_done_ff <= 1'b0;
         else if (step_en) c_done_ff <= c_done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) la_ff <= la_in;
      if (accept) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
      if (out_free && step_en && emit_ok) begin
         rsp_kind_ff   <= e_kind;
         rsp_byte_ff   <= e_byte;
         rsp_cvalid_ff <= e_cvalid;
         rsp_done_ff   <= e_done;
         rsp_err_ff    <= e_err;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_node_kind     = rsp_kind_ff;
   assign rsp_content_byte  = rsp_byte_ff;
   assign rsp_content_valid = rsp_cvalid_ff;
   assign rsp_node_done     = rsp_done_ff;
   assign rsp_error_code    = rsp_err_ff;

   a_err_on_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_err_ff != xts_pkg::ERR_NONE |-> rsp_done_ff && !rsp_cvalid_ff)
      else $error("error code on a content item");

   a_replay_range: assert property (@(posedge clock) disable iff (reset)
      rp_pos_ff <= rp_end_ff || rp_end_ff <= 3'd1)
      else $error("replay pointer out of range");

   a_replay_mode: assert property (@(posedge clock) disable iff (reset)
      replaying |-> mode_ff != xts_pkg::MODE_LOOK && mode_ff != xts_pkg::MODE_COMMENT &&
                    mode_ff != xts_pkg::MODE_DECL)
      else $error("replay entered an opener mode");

   a_emit_cap: assert property (@(posedge clock) disable iff (reset)
      emit_cnt_ff <= 3'(xts_pkg::MAX_RESULTS))
      else $error("too many results for one item");

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps

module tb;

   typedef struct packed {
      xts_pkg::kind_type kind;
      logic [7:0]        cbyte;
      logic              cvalid;
      logic              done;
      xts_pkg::err_type  err;
   } token_type;

   typedef struct {
      logic [7:0] data;
      logic       last;
      int         gap;
      bit         hold;
   } byte_item_type;

   localparam logic [7:0] COMMENT_OPEN [4] = '{xts_pkg::CH_LT, xts_pkg::CH_BANG,
                                               xts_pkg::CH_DASH, xts_pkg::CH_DASH};
   localparam logic [7:0] DECL_OPEN    [5] = '{xts_pkg::CH_LT, xts_pkg::CH_QMARK,
                                               xts_pkg::CH_X, xts_pkg::CH_M, xts_pkg::CH_L};
   localparam int TAIL_CYCLES = 50;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_last_byte = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [2:0] rsp_node_kind;
   logic [7:0] rsp_content_byte;
   logic       rsp_content_valid;
   logic       rsp_node_done;
   logic [1:0] rsp_error_code;

   xml_token_scanner u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_last_byte     (req_last_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_node_kind     (rsp_node_kind),
      .rsp_content_byte  (rsp_content_byte),
      .rsp_content_valid (rsp_content_valid),
      .rsp_node_done     (rsp_node_done),
      .rsp_error_code    (rsp_error_code)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------- scanner state mirror ----------------
   xts_pkg::mode_type lx_mode = xts_pkg::MODE_IDLE;
   logic [7:0] lx_look [4];
   int         lx_count = 0;
   logic       lx_inside = 1'b0;
   logic       lx_dq = 1'b0;
   int         lx_len = 0;
   logic [7:0] replay_q [$];
   int         item_tokens;
   token_type  tokens_due [$];

   function automatic bit name_char(input logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
             c == "_" || c == "." || c == xts_pkg::CH_DASH;
   endfunction

   function automatic void emit_token(input xts_pkg::kind_type k, input logic [7:0] b,
                                      input logic v, input logic d,
                                      input xts_pkg::err_type e);
      token_type t;
      if (item_tokens >= xts_pkg::MAX_RESULTS) return;
      t.kind = k;
      t.cbyte = b;
      t.cvalid = v;
      t.done = d;
      t.err = e;
      tokens_due.push_back(t);
      item_tokens++;
   endfunction

   function automatic void put_content(input xts_pkg::kind_type k, input logic [7:0] b);
      emit_token(k, b, 1'b1, 1'b0, xts_pkg::ERR_NONE);
   endfunction

   function automatic void close_node(input xts_pkg::kind_type k, input xts_pkg::err_type e);
      emit_token(k, 8'h00, 1'b0, 1'b1, e);
   endfunction

   // failed opener: '<' becomes an element, buffered bytes are scanned again
   function automatic void reopen_as_element();
      for (int k = lx_count - 1; k >= 1; k--) replay_q.push_front(lx_look[k]);
      lx_count = 0;
      lx_mode = xts_pkg::MODE_ELEM;
      lx_len = 0;
   endfunction

   function automatic void scan_stream();
      logic [7:0] c;
      bit again;
      bit is_com;
      int plen;
      logic [7:0] pat;
      while (replay_q.size() != 0) begin
         c = replay_q.pop_front();
         again = 1;
         while (again) begin
            again = 0;
            case (lx_mode)
               xts_pkg::MODE_IDLE: begin
                  if (c == xts_pkg::CH_LT) begin
                     lx_look[0] = c;
                     lx_count = 1;
                     lx_mode = xts_pkg::MODE_LOOK;
                  end else if (c == xts_pkg::CH_SPACE && lx_inside) begin
                     lx_mode = xts_pkg::MODE_ASPACE;
                     lx_len = 0;
                  end else if (c == xts_pkg::CH_GT && lx_inside) begin
                     lx_inside = 1'b0;
                  end else begin
                     lx_mode = xts_pkg::MODE_TEXT;
                     lx_len = 0;
                     again = 1;
                  end
               end
               xts_pkg::MODE_TEXT: begin
                  if (c == xts_pkg::CH_LT) begin
                     close_node(xts_pkg::KIND_TEXT, xts_pkg::ERR_NONE);
                     lx_mode = xts_pkg::MODE_IDLE;
                     again = 1;
                  end else if (c != xts_pkg::CH_LF) begin
                     if (lx_len < xts_pkg::TOKEN_LIMIT) begin
                        put_content(xts_pkg::KIND_TEXT, c);
                        lx_len++;
                     end else begin
                        close_node(xts_pkg::KIND_TEXT, xts_pkg::ERR_NONE);
                        lx_mode = xts_pkg::MODE_IDLE;
                        again = 1;
                     end
                  end
               end
               xts_pkg::MODE_LOOK: begin
                  is_com = (lx_look[1] == xts_pkg::CH_BANG);
                  plen = is_com ? 4 : 5;
                  pat = is_com ? COMMENT_OPEN[lx_count % 4] : DECL_OPEN[lx_count % 5];
                  if (lx_count == 1 && c == xts_pkg::CH_SLASH) begin
                     lx_count = 0;
                     lx_mode = xts_pkg::MODE_END;
                     lx_len = 0;
                  end else if (lx_count == 1 &&
                               (c == xts_pkg::CH_BANG || c == xts_pkg::CH_QMARK)) begin
                     lx_look[1] = c;
                     lx_count = 2;
                  end else if (lx_count >= 2 && lx_count < plen && c == pat) begin
                     if (lx_count + 1 == plen) begin
                        lx_count = 0;
                        lx_mode = is_com ? xts_pkg::MODE_COMMENT : xts_pkg::MODE_DECL;
                     end else begin
                        lx_look[lx_count] = c;
                        lx_count++;
                     end
                  end else begin
                     replay_q.push_front(c);
                     reopen_as_element();
                  end
               end
               xts_pkg::MODE_ELEM: begin
                  if (name_char(c)) begin
                     if (lx_len < xts_pkg::TOKEN_LIMIT) begin
                        put_content(xts_pkg::KIND_ELEM, c);
                        lx_len++;
                     end else begin
                        close_node(xts_pkg::KIND_ELEM, xts_pkg::ERR_NONE);
                        lx_mode = xts_pkg::MODE_IDLE;
                        again = 1;
                     end
                  end else begin
                     close_node(xts_pkg::KIND_ELEM, xts_pkg::ERR_NONE);
                     lx_mode = xts_pkg::MODE_IDLE;
                     if (c == xts_pkg::CH_GT) begin
                        lx_inside = 1'b0;
                     end else begin
                        lx_inside = 1'b1;
                        again = 1;
                     end
                  end
               end
               xts_pkg::MODE_END: begin
                  if (name_char(c)) begin
                     if (lx_len < xts_pkg::TOKEN_LIMIT) begin
                        put_content(xts_pkg::KIND_END, c);
                        lx_len++;
                     end
                  end else begin
                     close_node(xts_pkg::KIND_END, xts_pkg::ERR_NONE);
                     lx_inside = 1'b0;
                     lx_mode = xts_pkg::MODE_IDLE;
                     again = (c != xts_pkg::CH_GT);
                  end
               end
               xts_pkg::MODE_ASPACE: begin
                  if (c != xts_pkg::CH_SPACE && c != xts_pkg::CH_TAB) begin
                     lx_mode = name_char(c) ? xts_pkg::MODE_ANAME : xts_pkg::MODE_AEQ;
                     again = 1;
                  end
               end
               xts_pkg::MODE_ANAME: begin
                  if (name_char(c)) begin
                     if (lx_len < xts_pkg::TOKEN_LIMIT) begin
                        put_content(xts_pkg::KIND_ANAME, c);
                        lx_len++;
                     end
                  end else begin
                     lx_mode = xts_pkg::MODE_AEQ;
                     again = 1;
                  end
               end
               xts_pkg::MODE_AEQ: begin
                  if (c == xts_pkg::CH_EQ) lx_mode = xts_pkg::MODE_AQUOTE;
               end
               xts_pkg::MODE_AQUOTE: begin
                  if (c == xts_pkg::CH_DQ || c == xts_pkg::CH_SQ) begin
                     lx_dq = (c == xts_pkg::CH_DQ);
                     lx_len = 0;
                     lx_mode = xts_pkg::MODE_AVAL;
                  end else begin
                     close_node(xts_pkg::KIND_AVAL, xts_pkg::ERR_QUOTE);
                     lx_mode = xts_pkg::MODE_IDLE;
                     again = 1;
                  end
               end
               xts_pkg::MODE_AVAL: begin
                  if (c == (lx_dq ? xts_pkg::CH_DQ : xts_pkg::CH_SQ)) begin
                     close_node(xts_pkg::KIND_AVAL, xts_pkg::ERR_NONE);
                     lx_mode = xts_pkg::MODE_IDLE;
                  end else if (lx_len < xts_pkg::TOKEN_LIMIT) begin
                     put_content(xts_pkg::KIND_AVAL, c);
                     lx_len++;
                  end
               end
               xts_pkg::MODE_COMMENT: begin
                  if (c == xts_pkg::CH_DASH) begin
                     if (lx_count < 2) lx_count++;
                  end else if (c == xts_pkg::CH_GT && lx_count >= 2) begin
                     close_node(xts_pkg::KIND_COMMENT, xts_pkg::ERR_NONE);
                     lx_count = 0;
                     lx_mode = xts_pkg::MODE_IDLE;
                  end else begin
                     lx_count = 0;
                  end
               end
               xts_pkg::MODE_DECL: begin
                  if (c == xts_pkg::CH_GT && lx_count != 0) begin
                     close_node(xts_pkg::KIND_DECL, xts_pkg::ERR_NONE);
                     lx_count = 0;
                     lx_mode = xts_pkg::MODE_IDLE;
                  end else begin
                     lx_count = (c == xts_pkg::CH_QMARK) ? 1 : 0;
                  end
               end
               default: begin
                  lx_mode = xts_pkg::MODE_IDLE;
                  again = 1;
               end
            endcase
         end
      end
   endfunction

   function automatic void scan_item(input logic [7:0] data, input logic last);
      item_tokens = 0;
      replay_q.push_back(data);
      scan_stream();
      if (last) begin
         while (lx_mode == xts_pkg::MODE_LOOK) begin
            reopen_as_element();
            scan_stream();
         end
         case (lx_mode)
            xts_pkg::MODE_TEXT:    close_node(xts_pkg::KIND_TEXT, xts_pkg::ERR_NONE);
            xts_pkg::MODE_ELEM:    close_node(xts_pkg::KIND_ELEM, xts_pkg::ERR_NONE);
            xts_pkg::MODE_END:     close_node(xts_pkg::KIND_END, xts_pkg::ERR_NONE);
            xts_pkg::MODE_ASPACE, xts_pkg::MODE_ANAME, xts_pkg::MODE_AEQ,
            xts_pkg::MODE_AQUOTE, xts_pkg::MODE_AVAL:
               close_node(xts_pkg::KIND_AVAL, xts_pkg::ERR_QUOTE);
            xts_pkg::MODE_COMMENT: close_node(xts_pkg::KIND_COMMENT, xts_pkg::ERR_COMMENT);
            xts_pkg::MODE_DECL:    close_node(xts_pkg::KIND_DECL, xts_pkg::ERR_DECL);
            default: ;
         endcase
         lx_mode = xts_pkg::MODE_IDLE;
         lx_count = 0;
         lx_inside = 1'b0;
         lx_dq = 1'b0;
         lx_len = 0;
      end
   endfunction

   // ---------------- stimulus building ----------------
   byte_item_type byte_items [$];
   bit            send_calm = 0;
   bit            hold_next = 0;

   function automatic void push_byte(input logic [7:0] b);
      byte_item_type it;
      if ($urandom_range(0, 29) == 0) send_calm = !send_calm;
      it.data = b;
      it.last = 1'b0;
      it.gap = send_calm ? 0 : $urandom_range(0, 19);
      it.hold = hold_next || ($urandom_range(0, 59) == 0);
      hold_next = 0;
      byte_items.push_back(it);
   endfunction

   function automatic void push_str(input string s);
      for (int i = 0; i < s.len(); i++) push_byte(s[i]);
   endfunction

   function automatic void end_document();
      byte_item_type it;
      it = byte_items.pop_back();
      it.last = 1'b1;
      byte_items.push_back(it);
   endfunction

   function automatic logic [7:0] rand_name_char();
      case ($urandom_range(0, 7))
         0: return "_";
         1: return ".";
         2: return xts_pkg::CH_DASH;
         3, 4: return 8'("A" + $urandom_range(0, 25));
         default: return 8'("a" + $urandom_range(0, 25));
      endcase
   endfunction

   function automatic void push_name(input int n);
      for (int i = 0; i < n; i++) push_byte(rand_name_char());
   endfunction

   function automatic void push_text(input int n);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 9))
            0: push_byte(xts_pkg::CH_LF);
            1: push_byte(xts_pkg::CH_SPACE);
            2: push_byte(8'($urandom_range(0, 255)));
            default: push_byte(8'("a" + $urandom_range(0, 25)));
         endcase
      end
   endfunction

   function automatic void push_value(input int n, input logic [7:0] q);
      logic [7:0] b;
      for (int i = 0; i < n; i++) begin
         b = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                        : 8'("0" + $urandom_range(0, 40));
         if (b == q) b = "v";
         push_byte(b);
      end
   endfunction

   function automatic void push_start_tag();
      logic [7:0] q;
      push_byte(xts_pkg::CH_LT);
      push_name($urandom_range(1, 6));
      repeat ($urandom_range(0, 2)) begin
         push_byte(xts_pkg::CH_SPACE);
         if ($urandom_range(0, 3) == 0)
            push_byte($urandom_range(0, 1) ? xts_pkg::CH_TAB : xts_pkg::CH_SPACE);
         push_name($urandom_range(1, 5));
         if ($urandom_range(0, 7) != 0) begin
            push_byte(xts_pkg::CH_EQ);
            if ($urandom_range(0, 9) == 0) begin
               push_name(2);
            end else begin
               q = $urandom_range(0, 1) ? xts_pkg::CH_DQ : xts_pkg::CH_SQ;
               push_byte(q);
               push_value($urandom_range(0, 6), q);
               push_byte(q);
            end
         end
      end
      case ($urandom_range(0, 7))
         0: push_str("/>");
         1: ;
         default: push_byte(xts_pkg::CH_GT);
      endcase
   endfunction

   function automatic void push_piece();
      case ($urandom_range(0, 9))
         0, 1: push_text($urandom_range(1, 8));
         2, 3: push_start_tag();
         4: begin
            push_str("</");
            push_name($urandom_range(1, 6));
            push_byte($urandom_range(0, 4) ? xts_pkg::CH_GT : xts_pkg::CH_SPACE);
         end
         5: begin
            push_str("<!--");
            repeat ($urandom_range(0, 5))
               push_byte($urandom_range(0, 2) ? "c" : xts_pkg::CH_DASH);
            push_str("-->");
         end
         6: begin
            push_str("<?xml");
            repeat ($urandom_range(0, 5))
               push_byte($urandom_range(0, 2) ? "v" : xts_pkg::CH_QMARK);
            push_str("?>");
         end
         7: repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
         default: begin
            case ($urandom_range(0, 6))
               0: push_str("<!-x");
               1: push_str("<?x");
               2: push_str("<!");
               3: push_str("<?xm");
               4: push_str("<a b='xx");
               5: push_str("<");
               default: push_str("</");
            endcase
         end
      endcase
   endfunction

   // ---------------- sender ----------------
   int            sent_n = 0;
   int            accepted_n = 0;
   byte_item_type next_item;
   bit            have_next = 0;
   int            wait_left = 0;

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data_byte <= 8'h00;
         req_last_byte <= 1'b0;
      end else if (!(req_valid && accepted_n != sent_n)) begin
         if (!have_next && byte_items.size() != 0) begin
            next_item = byte_items.pop_front();
            have_next = 1;
            wait_left = next_item.gap;
         end
         if (have_next && wait_left == 0 && !(next_item.hold && tokens_due.size() != 0)) begin
            req_valid <= 1'b1;
            req_data_byte <= next_item.data;
            req_last_byte <= next_item.last;
            sent_n++;
            have_next = 0;
         end else begin
            req_valid <= 1'b0;
            if (have_next && wait_left > 0) wait_left--;
         end
      end
   end

   // ---------------- receiver ----------------
   int rsp_taken_n = 0;
   int rsp_seen_n = 0;
   int recv_wait = 0;
   bit recv_calm = 0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_taken_n != rsp_seen_n) begin
            rsp_seen_n = rsp_taken_n;
            if ($urandom_range(0, 29) == 0) recv_calm = !recv_calm;
            recv_wait = recv_calm ? 0 : $urandom_range(0, 19);
         end else if (recv_wait != 0) begin
            recv_wait--;
         end
         rsp_stall <= (recv_wait != 0);
      end
   end

   // ---------------- monitor ----------------
   int fails = 0;

   always @(posedge clock) begin
      token_type exp;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            scan_item(req_data_byte, req_last_byte);
            accepted_n++;
         end
         if (rsp_valid && !rsp_stall) begin
            rsp_taken_n++;
            if (tokens_due.size() == 0) begin
               $error("result with nothing expected: kind %0d byte %0h", rsp_node_kind,
                      rsp_content_byte);
               fails++;
            end else begin
               exp = tokens_due.pop_front();
               if (rsp_node_kind !== exp.kind) begin
                  $error("node_kind: expected %0d, got %0d", exp.kind, rsp_node_kind);
                  fails++;
               end
               if (rsp_content_byte !== exp.cbyte) begin
                  $error("content_byte: expected %0h, got %0h", exp.cbyte, rsp_content_byte);
                  fails++;
               end
               if (rsp_content_valid !== exp.cvalid) begin
                  $error("content_valid: expected %0d, got %0d", exp.cvalid,
                         rsp_content_valid);
                  fails++;
               end
               if (rsp_node_done !== exp.done) begin
                  $error("node_done: expected %0d, got %0d", exp.done, rsp_node_done);
                  fails++;
               end
               if (rsp_error_code !== exp.err) begin
                  $error("error_code: expected %0d, got %0d", exp.err, rsp_error_code);
                  fails++;
               end
            end
         end
      end
   end

   initial begin
      #10_000_000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      // directed documents
      push_str("<a k='");
      push_byte(8'hFF);
      push_str("'>");
      push_byte(xts_pkg::CH_LF);
      push_str("</b ");
      end_document();
      push_str("<!");
      end_document();
      push_str("<?xml");
      end_document();
      push_str("<!--");
      end_document();
      push_str("<a b=");
      push_byte(8'h00);
      end_document();

      // random documents; the first random item waits for the scanner to drain
      hold_next = 1;
      while (byte_items.size() < 350) begin
         repeat ($urandom_range(1, 10)) push_piece();
         end_document();
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (byte_items.size() != 0 || have_next || accepted_n != sent_n ||
             tokens_due.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (fails == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
